### rtl/assert_macros.svh
// assertion helpers, all checks sample on clk and are off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, cond, msg)

`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### rtl/lfcg_pkg.sv
`timescale 1ns / 1ps

package lfcg_pkg;

  localparam int unsigned MAX_TEXT_LENGTH = 4096;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned CNT_W         = 13;
  localparam int unsigned LETTER_W      = 5;
  localparam int unsigned KIND_W        = 2;
  localparam int unsigned NUM_LETTERS   = 26;
  localparam int unsigned CNT_MAX       = 8191;
  localparam int unsigned TARGET_LETTER = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_CAESAR  = 2'd1,
    KIND_BASE64  = 2'd2
  } kind_t;

  function automatic logic is_upper(input logic [BYTE_W-1:0] b);
    return (b >= 8'h41) && (b <= 8'h5a);
  endfunction

  function automatic logic is_lower(input logic [BYTE_W-1:0] b);
    return (b >= 8'h61) && (b <= 8'h7a);
  endfunction

  function automatic logic is_base64(input logic [BYTE_W-1:0] b);
    logic digit;
    digit = (b >= 8'h30) && (b <= 8'h39);
    return is_upper(b) || is_lower(b) || digit ||
           (b == 8'h2b) || (b == 8'h2f) || (b == 8'h3d);
  endfunction

endpackage

### rtl/lfcg_if.sv
`timescale 1ns / 1ps

interface lfcg_in_if;
  logic                         valid;
  logic                         ready;
  logic [lfcg_pkg::BYTE_W-1:0]  text_byte;
  logic                         last_byte;
  logic                         empty_text;

  modport source (output valid, text_byte, last_byte, empty_text, input ready);
  modport sink   (input valid, text_byte, last_byte, empty_text, output ready);
endinterface

interface lfcg_out_if;
  logic                           valid;
  logic                           ready;
  logic [lfcg_pkg::LETTER_W-1:0]  guessed_shift;
  logic [lfcg_pkg::KIND_W-1:0]    detected_kind;
  logic [lfcg_pkg::LETTER_W-1:0]  top_letter;
  logic [lfcg_pkg::CNT_W-1:0]     top_count;

  modport source (output valid, guessed_shift, detected_kind, top_letter, top_count,
                  input ready);
  modport sink   (input valid, guessed_shift, detected_kind, top_letter, top_count,
                  output ready);
endinterface

### rtl/letter_frequency_cipher_guesser.sv
`timescale 1ns / 1ps

// Letter frequency cipher guesser. Text streams in one byte per transfer with last_byte on
// the final byte, or as a single empty_text transfer for a zero-length text (empty_text
// after some bytes closes the text without adding a byte). Letters are counted case-blind
// in 26 saturating counters, the length saturates at the smaller of MAX_TEXT_LENGTH and
// 8191, and every byte is checked against the base64 alphabet. Each closed text gives one
// result: top letter (lowest index on ties), its count, the shift mapping it onto E, and
// a class (2 base64, 1 probable Caesar, 0 unknown); all per-text state is then cleared.
// Throughput is one byte per clock, set by the single counter increment and running
// maximum update done per byte in the stage after the input register. A result is
// written to the output register when its closing item leaves the input register. The input
// side only stalls when a closing item meets a result that has not yet been taken.

`include "assert_macros.svh"

module letter_frequency_cipher_guesser #(
  parameter int unsigned MAX_TEXT_LENGTH = lfcg_pkg::MAX_TEXT_LENGTH
) (
  input  logic            clk,
  input  logic            rst,
  lfcg_in_if.sink         text_in,
  lfcg_out_if.source      result_out
);

  localparam int unsigned CW  = lfcg_pkg::CNT_W;
  localparam int unsigned LW  = lfcg_pkg::LETTER_W;
  localparam int unsigned BW  = lfcg_pkg::BYTE_W;
  localparam int unsigned NL  = lfcg_pkg::NUM_LETTERS;
  localparam int unsigned LIMIT_INT =
    (MAX_TEXT_LENGTH < lfcg_pkg::CNT_MAX) ? MAX_TEXT_LENGTH : lfcg_pkg::CNT_MAX;
  localparam logic [CW-1:0] LIMIT      = CW'(LIMIT_INT);
  localparam logic [LW-1:0] TARGET     = LW'(lfcg_pkg::TARGET_LETTER);
  localparam logic [LW-1:0] WRAP_SHIFT = LW'(lfcg_pkg::NUM_LETTERS - lfcg_pkg::TARGET_LETTER);

  // input register
  logic          s1_valid;
  logic [BW-1:0] s1_byte;
  logic          s1_last;
  logic          s1_empty;

  // per-text state
  logic [CW-1:0] counts [NL];
  logic [CW-1:0] text_len;
  logic          all_b64;
  logic [LW-1:0] top_letter;
  logic [CW-1:0] top_cnt;

  // result register
  logic                  out_valid;
  logic [LW-1:0]         res_shift;
  lfcg_pkg::kind_t       res_kind;
  logic [LW-1:0]         res_letter;
  logic [CW-1:0]         res_cnt;

  logic s1_end, out_free, s1_fire, in_fire, take, emit;
  logic is_up, is_lo, is_letter;
  logic [BW-1:0] up_off, lo_off;
  logic [LW-1:0] idx;
  logic [CW-1:0] cur_cnt, inc_cnt;
  logic [CW-1:0] text_len_next, top_cnt_next;
  logic [LW-1:0] top_letter_next;
  logic          all_b64_next, upd;
  logic [CW+2:0] five_top;
  lfcg_pkg::kind_t kind_next;
  logic [LW-1:0]   shift_next;
  logic            text_cleared;

  assign s1_end   = s1_empty | s1_last;
  assign out_free = !out_valid || result_out.ready;
  assign s1_fire  = s1_valid && (!s1_end || out_free);
  assign emit     = s1_fire && s1_end;
  assign take     = s1_fire && !s1_empty;

  assign text_in.ready = !s1_valid || s1_fire;
  assign in_fire       = text_in.valid && text_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text_in.ready) begin
      s1_valid <= text_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte  <= text_in.text_byte;
      s1_last  <= text_in.last_byte;
      s1_empty <= text_in.empty_text;
    end
  end

  always_comb begin
    is_up     = lfcg_pkg::is_upper(s1_byte);
    is_lo     = lfcg_pkg::is_lower(s1_byte);
    is_letter = is_up || is_lo;
    up_off    = s1_byte - 8'h41;
    lo_off    = s1_byte - 8'h61;
    if (is_up) begin
      idx = up_off[LW-1:0];
    end else if (is_lo) begin
      idx = lo_off[LW-1:0];
    end else begin
      idx = '0;
    end

    cur_cnt = counts[idx];
    inc_cnt = (cur_cnt < LIMIT) ? cur_cnt + 1'b1 : cur_cnt;

    text_len_next = (take && (text_len < LIMIT)) ? text_len + 1'b1 : text_len;
    all_b64_next  = all_b64 & (!take | lfcg_pkg::is_base64(s1_byte));

    // a saturated count can still take the lead from a higher index on a tie
    upd = take && is_letter &&
          ((inc_cnt > top_cnt) || ((inc_cnt == top_cnt) && (idx < top_letter)));
    top_cnt_next    = upd ? inc_cnt : top_cnt;
    top_letter_next = upd ? idx : top_letter;

    // top > len/5 is the same as 5*top > len
    five_top = {top_cnt_next, 2'b00} + {3'b000, top_cnt_next};
    if ((text_len_next[1:0] == 2'b00) && all_b64_next) begin
      kind_next = lfcg_pkg::KIND_BASE64;
    end else if (five_top > {3'b000, text_len_next}) begin
      kind_next = lfcg_pkg::KIND_CAESAR;
    end else begin
      kind_next = lfcg_pkg::KIND_UNKNOWN;
    end

    shift_next = (top_letter_next >= TARGET) ? top_letter_next - TARGET
                                             : top_letter_next + WRAP_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst || emit) begin
      for (int i = 0; i < NL; i++) begin
        counts[i] <= '0;
      end
      text_len   <= '0;
      all_b64    <= 1'b1;
      top_letter <= '0;
      top_cnt    <= '0;
    end else if (take) begin
      if (is_letter) begin
        counts[idx] <= inc_cnt;
      end
      text_len   <= text_len_next;
      all_b64    <= all_b64_next;
      top_letter <= top_letter_next;
      top_cnt    <= top_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_shift  <= shift_next;
      res_kind   <= kind_next;
      res_letter <= top_letter_next;
      res_cnt    <= top_cnt_next;
    end
  end

  assign result_out.valid         = out_valid;
  assign result_out.guessed_shift = res_shift;
  assign result_out.detected_kind = res_kind;
  assign result_out.top_letter    = res_letter;
  assign result_out.top_count     = res_cnt;

  assign text_cleared = (text_len == '0) && (top_cnt == '0) && all_b64 && (top_letter == '0);

  `ASSERT_ALWAYS(a_no_overwrite, !(out_valid && !result_out.ready && emit), "result overwritten")
  `ASSERT_NEXT(a_clear_after_text, emit, text_cleared, "text state not cleared")
  `ASSERT_ALWAYS(a_top_within_len, (top_cnt <= text_len) && (top_letter < LW'(NL)), "top range")

endmodule

### bench/tb_letter_frequency_cipher_guesser.sv
`timescale 1ns / 1ps

module tb_letter_frequency_cipher_guesser;

  typedef struct packed {
    logic [lfcg_pkg::LETTER_W-1:0] shift;
    lfcg_pkg::kind_t               kind;
    logic [lfcg_pkg::LETTER_W-1:0] letter;
    logic [lfcg_pkg::CNT_W-1:0]    count;
  } guess_t;

  typedef enum {STYLE_RAW, STYLE_B64, STYLE_PROSE} text_style_t;
  typedef enum {CLOSE_LAST, CLOSE_MARK, CLOSE_BOTH} close_t;

  class shift_guess_tracker;
    logic [lfcg_pkg::CNT_W-1:0]    tally [lfcg_pkg::NUM_LETTERS];
    logic [lfcg_pkg::CNT_W-1:0]    span;
    bit                            b64_clean;
    logic [lfcg_pkg::LETTER_W-1:0] lead_idx;
    logic [lfcg_pkg::CNT_W-1:0]    lead_cnt;
    int unsigned                   count_cap;
    guess_t                        awaited_guesses [$];
    int                            errors;

    function new(int unsigned max_len);
      count_cap = (max_len < lfcg_pkg::CNT_MAX) ? max_len : lfcg_pkg::CNT_MAX;
      errors = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (tally[i]) tally[i] = '0;
      span = '0;
      b64_clean = 1'b1;
      lead_idx = '0;
      lead_cnt = '0;
    endfunction

    function bit in_b64_alphabet(logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || (b >= "0" && b <= "9") ||
             b == "+" || b == "/" || b == "=";
    endfunction

    function void note_text_item(logic [7:0] b, logic last, logic empty);
      guess_t g;
      int     idx;
      if (!empty) begin
        if (span < count_cap) span++;
        if (!in_b64_alphabet(b)) b64_clean = 1'b0;
        idx = -1;
        if (b >= "A" && b <= "Z") idx = int'(b) - int'("A");
        else if (b >= "a" && b <= "z") idx = int'(b) - int'("a");
        if (idx >= 0) begin
          if (tally[idx] < count_cap) tally[idx]++;
          if (tally[idx] > lead_cnt || (tally[idx] == lead_cnt && idx < lead_idx)) begin
            lead_idx = lfcg_pkg::LETTER_W'(idx);
            lead_cnt = tally[idx];
          end
        end
      end
      if (empty || last) begin
        if (span % 4 == 0 && b64_clean) g.kind = lfcg_pkg::KIND_BASE64;
        else if (lead_cnt > span / 5) g.kind = lfcg_pkg::KIND_CAESAR;
        else g.kind = lfcg_pkg::KIND_UNKNOWN;
        g.shift = lfcg_pkg::LETTER_W'((int'(lead_idx) + lfcg_pkg::NUM_LETTERS -
                                       lfcg_pkg::TARGET_LETTER) % lfcg_pkg::NUM_LETTERS);
        g.letter = lead_idx;
        g.count = lead_cnt;
        awaited_guesses.push_back(g);
        clear_text();
      end
    endfunction

    function void check_guess(guess_t got);
      guess_t want;
      if (awaited_guesses.size() == 0) begin
        $display("%0t: unexpected result shift=%0d kind=%0d letter=%0d count=%0d",
                 $time, got.shift, got.kind, got.letter, got.count);
        errors++;
        return;
      end
      want = awaited_guesses.pop_front();
      if (got.shift !== want.shift) begin
        $display("%0t: guessed_shift expected %0d actual %0d", $time, want.shift, got.shift);
        errors++;
      end
      if (got.kind !== want.kind) begin
        $display("%0t: detected_kind expected %0d actual %0d", $time, want.kind, got.kind);
        errors++;
      end
      if (got.letter !== want.letter) begin
        $display("%0t: top_letter expected %0d actual %0d", $time, want.letter, got.letter);
        errors++;
      end
      if (got.count !== want.count) begin
        $display("%0t: top_count expected %0d actual %0d", $time, want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  lfcg_in_if  in_if ();
  lfcg_out_if out_if ();

  letter_frequency_cipher_guesser uut (
    .clk        (clk),
    .rst        (rst),
    .text_in    (in_if),
    .result_out (out_if)
  );

  always #10 clk = ~clk;

  shift_guess_tracker board;
  string b64_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/=";
  bit    calm = 1'b0;
  bit    hold_req = 1'b0;
  int    items_sent = 0;

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int     hold_left;
    guess_t got;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_if.valid && out_if.ready) begin
        got.shift = out_if.guessed_shift;
        got.kind = lfcg_pkg::kind_t'(out_if.detected_kind);
        got.letter = out_if.top_letter;
        got.count = out_if.top_count;
        board.check_guess(got);
      end
      if (hold_req) begin
        hold_left = 200;
        hold_req = 1'b0;
      end
      if (rst) begin
        out_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= 8);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_item(input logic [7:0] b, input logic last, input logic empty);
    if (!calm && $urandom_range(99) < 8) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.text_byte <= b;
    in_if.last_byte <= last;
    in_if.empty_text <= empty;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    board.note_text_item(b, last, empty);
    items_sent++;
  endtask

  function automatic logic [7:0] pick_byte(text_style_t style, int favored);
    logic [7:0] c;
    case (style)
      STYLE_RAW: c = 8'($urandom_range(255));
      STYLE_B64: c = b64_chars[$urandom_range(64)];
      default: begin
        if ($urandom_range(9) < 4) c = 8'("a" + favored);
        else if ($urandom_range(9) == 0) c = " ";
        else c = 8'("a" + $urandom_range(25));
        // upper case half the time
        if (c != " " && $urandom_range(1)) c[5] = 1'b0;
      end
    endcase
    return c;
  endfunction

  task automatic send_text(input text_style_t style, input int len, input close_t close);
    int favored;
    favored = $urandom_range(25);
    for (int i = 0; i < len; i++)
      send_item(pick_byte(style, favored), close == CLOSE_LAST && i == len - 1, 1'b0);
    if (close != CLOSE_LAST)
      send_item(8'($urandom_range(255)), close == CLOSE_BOTH, 1'b1);
  endtask

  initial begin
    int          texts;
    int          len;
    text_style_t style;
    close_t      close;
    board = new(lfcg_pkg::MAX_TEXT_LENGTH);
    in_if.valid = 1'b0;
    in_if.text_byte = '0;
    in_if.last_byte = 1'b0;
    in_if.empty_text = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty text on its own
    send_item(8'hff, 1'b0, 1'b1);
    // zero byte alone
    send_item(8'h00, 1'b1, 1'b0);
    // letter extremes, mixed case
    send_item("A", 1'b0, 1'b0);
    send_item("z", 1'b0, 1'b0);
    send_item("Z", 1'b1, 1'b0);
    // base64 symbols with no letters
    send_item("+", 1'b0, 1'b0);
    send_item("/", 1'b0, 1'b0);
    send_item("=", 1'b0, 1'b0);
    send_item("9", 1'b1, 1'b0);
    // empty mark closing a text, with a high byte inside
    send_item("e", 1'b0, 1'b0);
    send_item("E", 1'b0, 1'b0);
    send_item(8'h80, 1'b0, 1'b0);
    send_item("0", 1'b0, 1'b1);
    // tie goes to the lower letter
    send_item("b", 1'b0, 1'b0);
    send_item("a", 1'b1, 1'b0);
    // last and empty together: the byte is dropped
    send_item("x", 1'b0, 1'b0);
    send_item("x", 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);

    texts = 0;
    while (items_sent < 1150) begin
      calm = (texts >= 40 && texts < 70);
      if (texts == 20) hold_req = 1'b1;
      case ($urandom_range(19))
        0: begin
          // noise with random flags
          repeat ($urandom_range(1, 6))
            send_item(8'($urandom_range(255)), $urandom_range(7) == 0,
                      $urandom_range(15) == 0);
        end
        1: send_text(STYLE_PROSE, 0, CLOSE_MARK);
        default: begin
          style = text_style_t'($urandom_range(2));
          case (style)
            STYLE_RAW: len = $urandom_range(1, 16);
            STYLE_B64: len = $urandom_range(3) ? 4 * $urandom_range(1, 6) : $urandom_range(1, 24);
            default: len = $urandom_range(1, 30);
          endcase
          case ($urandom_range(9))
            0: close = CLOSE_MARK;
            1: close = CLOSE_BOTH;
            default: close = CLOSE_LAST;
          endcase
          send_text(style, len, close);
        end
      endcase
      texts++;
    end
    calm = 1'b0;
    in_if.valid <= 1'b0;

    while (board.awaited_guesses.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
